// ===== rtl/core/lfd_pkg.sv =====
// Shared types and constants of the diamond column loop filter.
package lfd_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int BITS_CFG_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_VERT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS = 3'd4;

    // Filter shape
    localparam int COEF_W    = 16;
    localparam int NUM_TAPS  = 9;
    localparam int COL_ROWS  = 7;
    localparam int NUM_CELLS = 6;

    // Rounding: (sum + 32) >> 6
    localparam int ROUND_OFFSET = 32;
    localparam int ROUND_SHIFT  = 6;

    // Columns needed before a row yields its first pixel
    localparam logic [2:0] FILL_FULL = 3'd7;

    // Control that travels with a request into the arithmetic pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

// ===== rtl/core/lfd_col_if.sv =====
// Channel carrying one padded column of seven samples.
interface lfd_col_if #(
    parameter int W = 10
);
    logic         valid;
    logic         ready;
    logic [W-1:0] above_three;
    logic [W-1:0] above_two;
    logic [W-1:0] above_one;
    logic [W-1:0] center_sample;
    logic [W-1:0] below_one;
    logic [W-1:0] below_two;
    logic [W-1:0] below_three;
    logic         row_begin;
    logic         row_end;

    modport source (
        output valid, above_three, above_two, above_one, center_sample,
               below_one, below_two, below_three, row_begin, row_end,
        input  ready
    );
    modport sink (
        input  valid, above_three, above_two, above_one, center_sample,
               below_one, below_two, below_three, row_begin, row_end,
        output ready
    );
endinterface

// ===== rtl/core/lfd_pix_if.sv =====
// Channel carrying one filtered pixel.
interface lfd_pix_if #(
    parameter int W = 10
);
    logic         valid;
    logic         ready;
    logic [W-1:0] filtered_sample;
    logic         last_in_row;

    modport source (
        output valid, filtered_sample, last_in_row,
        input  ready
    );
    modport sink (
        input  valid, filtered_sample, last_in_row,
        output ready
    );
endinterface

// ===== rtl/core/lfd_col_cell.sv =====
// One cell of the column shift chain: holds a full seven-sample column.
module lfd_col_cell #(
    parameter int W = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_shift,
    input  logic [lfd_pkg::COL_ROWS-1:0][W-1:0]    i_col,
    output logic [lfd_pkg::COL_ROWS-1:0][W-1:0]    o_col
);

    logic [lfd_pkg::COL_ROWS-1:0][W-1:0] r_col;
    logic [lfd_pkg::COL_ROWS-1:0][W-1:0] n_col;

    // Take the neighbor's column on every accepted request
    always_comb begin
        n_col = i_shift ? i_col : r_col;
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

// ===== rtl/core/lfd_mac.sv =====
// Multiply, add tree, rounding and clamp pipeline with an output register.
module lfd_mac #(
    parameter int W = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request side
    input  lfd_pkg::t_stage_ctl                   i_ctl,
    output logic                                  o_ready,
    input  logic [W:0]                            i_pair [lfd_pkg::NUM_TAPS],
    input  logic signed [lfd_pkg::COEF_W-1:0]     i_coef [lfd_pkg::NUM_TAPS],
    input  logic [lfd_pkg::BITS_CFG_W-1:0]        i_bits,
    // result side
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [W-1:0]                          o_sample,
    output logic                                  o_last
);

    localparam int PW     = lfd_pkg::COEF_W + W + 2;   // product width
    localparam int SW     = PW + 4;                    // sum width, nine products
    localparam int GROUPS = lfd_pkg::NUM_TAPS / 3;

    lfd_pkg::t_stage_ctl r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic signed [PW-1:0] r_prod [lfd_pkg::NUM_TAPS];
    logic signed [PW-1:0] n_prod [lfd_pkg::NUM_TAPS];
    logic signed [SW-1:0] r_part [GROUPS];
    logic signed [SW-1:0] n_part [GROUPS];
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    logic [W-1:0]         r_sample;
    logic [W-1:0]         n_sample;
    logic                 w_en1, w_en2, w_en3, w_en4;

    // Stage enables: a stage moves when empty or when its successor moves
    assign w_en4   = !r_ctl4.valid || i_ready;
    assign w_en3   = !r_ctl3.valid || w_en4;
    assign w_en2   = !r_ctl2.valid || w_en3;
    assign w_en1   = !r_ctl1.valid || w_en2;
    assign o_ready = w_en1;

    // Stage 1: one multiplier per tap
    always_comb begin
        for (int k = 0; k < lfd_pkg::NUM_TAPS; k++) begin
            n_prod[k] = i_coef[k] * $signed({1'b0, i_pair[k]});
        end
    end

    // Stage 2: three groups of three products
    always_comb begin
        for (int j = 0; j < GROUPS; j++) begin
            n_part[j] = SW'(r_prod[3*j]) + SW'(r_prod[3*j+1]) + SW'(r_prod[3*j+2]);
        end
    end

    // Stage 3: final add with rounding offset
    always_comb begin
        n_sum = r_part[0] + r_part[1] + r_part[2] + SW'(lfd_pkg::ROUND_OFFSET);
    end

    // Stage 4: floor shift, then clamp to 0..2^bits-1
    always_comb begin
        logic signed [SW-1:0]           q;
        logic signed [SW-1:0]           maxv;
        logic [lfd_pkg::BITS_CFG_W-1:0] bits;
        bits = (i_bits < lfd_pkg::BITS_CFG_W'(W)) ? i_bits : lfd_pkg::BITS_CFG_W'(W);
        maxv = (SW'(1) << bits) - SW'(1);
        q    = r_sum >>> lfd_pkg::ROUND_SHIFT;
        priority if (q < 0) begin
            n_sample = '0;
        end else if (q > maxv) begin
            n_sample = W'(maxv);
        end else begin
            n_sample = W'(q);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            if (w_en1) r_ctl1 <= i_ctl;
            if (w_en2) r_ctl2 <= r_ctl1;
            if (w_en3) r_ctl3 <= r_ctl2;
            if (w_en4) r_ctl4 <= r_ctl3;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_en1) r_prod   <= n_prod;
        if (w_en2) r_part   <= n_part;
        if (w_en3) r_sum    <= n_sum;
        if (w_en4) r_sample <= n_sample;
    end

    assign o_valid  = r_ctl4.valid;
    assign o_last   = r_ctl4.last;
    assign o_sample = r_sample;

endmodule

// ===== rtl/core/loop_filter_diamond_column_stream.sv =====
// Symmetric 7x7 diamond loop filter, one padded column per request.
//
// Input channel i_col carries one column of seven vertically clamped samples
// (rows -3..+3) plus row_begin / row_end flags. Output channel o_pix carries
// the filtered pixel of the column three places back and its last_in_row flag.
// The first six columns of a row give no pixel; every further column gives one.
// Coefficients and clamp depth must be written by the user through i_cfg_we /
// i_cfg_index / i_cfg_data only while idle; the block does not enforce it.
//
// Throughput: one column per cycle until a stalled o_pix fills the pipeline.
// The column history is a chain of six cells that shift on each accepted
// request; the arithmetic is a four-stage pipeline (multiply, group add, final
// add, round and clamp), registered stage by stage up to o_pix.
// When o_pix stalls, the pipeline keeps filling its empty stages and i_col
// stays ready until all four stages hold a pixel; then ready drops.
// Reset (synchronous, active low) empties the pipeline, clears the column
// count and restores the default coefficients (center 64) and depth 10.
module loop_filter_diamond_column_stream #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lfd_col_if.sink                         i_col,
    lfd_pix_if.source                       o_pix
);

    localparam int W = SAMPLE_BITS;

    // Row positions inside a column
    localparam int UP3 = 0;
    localparam int UP2 = 1;
    localparam int UP1 = 2;
    localparam int MID = 3;
    localparam int DN1 = 4;
    localparam int DN2 = 5;
    localparam int DN3 = 6;

    logic [31:0]                         r_coef_vert;
    logic [47:0]                         r_coef_ring;
    logic [47:0]                         r_coef_row;
    logic signed [lfd_pkg::COEF_W-1:0]   r_coef_center;
    logic [lfd_pkg::BITS_CFG_W-1:0]      r_sample_bits;
    logic [2:0]                          r_fill;
    logic [2:0]                          n_fill;

    logic [lfd_pkg::COL_ROWS-1:0][W-1:0] w_col_in;
    logic [lfd_pkg::COL_ROWS-1:0][W-1:0] w_col [lfd_pkg::NUM_CELLS+1];
    logic [W:0]                          w_pair [lfd_pkg::NUM_TAPS];
    logic signed [lfd_pkg::COEF_W-1:0]   w_coef [lfd_pkg::NUM_TAPS];
    logic                                w_accept;
    logic                                w_mac_ready;
    lfd_pkg::t_stage_ctl                 w_ctl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vert   <= '0;
            r_coef_ring   <= '0;
            r_coef_row    <= '0;
            r_coef_center <= 16'sd64;
            r_sample_bits <= 4'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lfd_pkg::CFG_COEF_VERT:   r_coef_vert   <= i_cfg_data[31:0];
                lfd_pkg::CFG_COEF_RING:   r_coef_ring   <= i_cfg_data[47:0];
                lfd_pkg::CFG_COEF_ROW:    r_coef_row    <= i_cfg_data[47:0];
                lfd_pkg::CFG_COEF_CENTER: r_coef_center <= i_cfg_data[15:0];
                lfd_pkg::CFG_SAMPLE_BITS: r_sample_bits <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign w_accept    = i_col.valid && w_mac_ready;
    assign i_col.ready = w_mac_ready;

    // Columns seen in this row, saturating
    always_comb begin
        priority if (i_col.row_begin) begin
            n_fill = 3'd1;
        end else if (r_fill < lfd_pkg::FILL_FULL) begin
            n_fill = r_fill + 3'd1;
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

    // Incoming column
    assign w_col_in[UP3] = i_col.above_three;
    assign w_col_in[UP2] = i_col.above_two;
    assign w_col_in[UP1] = i_col.above_one;
    assign w_col_in[MID] = i_col.center_sample;
    assign w_col_in[DN1] = i_col.below_one;
    assign w_col_in[DN2] = i_col.below_two;
    assign w_col_in[DN3] = i_col.below_three;
    assign w_col[0]      = w_col_in;

    // Column history chain: w_col[k] holds column c-k
    for (genvar k = 0; k < lfd_pkg::NUM_CELLS; k++) begin : g_cell
        lfd_col_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_accept),
            .i_col   (w_col[k]),
            .o_col   (w_col[k+1])
        );
    end

    // Symmetric pairs around the output column c-3
    assign w_pair[0] = {1'b0, w_col[3][UP3]} + {1'b0, w_col[3][DN3]};
    assign w_pair[1] = {1'b0, w_col[3][UP2]} + {1'b0, w_col[3][DN2]};
    assign w_pair[2] = {1'b0, w_col[4][UP1]} + {1'b0, w_col[2][DN1]};
    assign w_pair[3] = {1'b0, w_col[3][UP1]} + {1'b0, w_col[3][DN1]};
    assign w_pair[4] = {1'b0, w_col[2][UP1]} + {1'b0, w_col[4][DN1]};
    assign w_pair[5] = {1'b0, w_col[6][MID]} + {1'b0, w_col[0][MID]};
    assign w_pair[6] = {1'b0, w_col[5][MID]} + {1'b0, w_col[1][MID]};
    assign w_pair[7] = {1'b0, w_col[4][MID]} + {1'b0, w_col[2][MID]};
    assign w_pair[8] = {1'b0, w_col[3][MID]};

    // Unpack coefficients
    assign w_coef[0] = r_coef_vert[15:0];
    assign w_coef[1] = r_coef_vert[31:16];
    assign w_coef[2] = r_coef_ring[15:0];
    assign w_coef[3] = r_coef_ring[31:16];
    assign w_coef[4] = r_coef_ring[47:32];
    assign w_coef[5] = r_coef_row[15:0];
    assign w_coef[6] = r_coef_row[31:16];
    assign w_coef[7] = r_coef_row[47:32];
    assign w_coef[8] = r_coef_center;

    // A pixel is due once seven columns of the row are in
    assign w_ctl.valid = w_accept && (n_fill == lfd_pkg::FILL_FULL);
    assign w_ctl.last  = i_col.row_end;

    lfd_mac #(
        .W (W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_ready  (w_mac_ready),
        .i_pair   (w_pair),
        .i_coef   (w_coef),
        .i_bits   (r_sample_bits),
        .o_valid  (o_pix.valid),
        .i_ready  (o_pix.ready),
        .o_sample (o_pix.filtered_sample),
        .o_last   (o_pix.last_in_row)
    );

endmodule

// ===== dv/lfd_pixel_check.sv =====
// Monitor, filter prediction and pixel comparison for the diamond column loop filter.
module lfd_pixel_check #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lfd_col_if                             col,
    lfd_pix_if                             pix,
    output int                             o_error_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = SAMPLE_BITS;

    // Far rows of one column: -3, -2, +2, +3
    typedef struct packed {
        logic [W-1:0] up3;
        logic [W-1:0] up2;
        logic [W-1:0] dn2;
        logic [W-1:0] dn3;
    } t_far_rows;

    typedef struct packed {
        logic [W-1:0] value;
        logic         last;
    } t_pixel;

    // Mirror of the coefficient registers
    logic [31:0]                       coef_vert;
    logic [47:0]                       coef_ring;
    logic [47:0]                       coef_row;
    logic signed [lfd_pkg::COEF_W-1:0] coef_mid;
    logic [lfd_pkg::BITS_CFG_W-1:0]    clamp_depth;

    // Column history, index 0 is the previous column
    logic [W-1:0] mid_hist [6];
    logic [W-1:0] up_hist  [4];
    logic [W-1:0] dn_hist  [4];
    t_far_rows    far_hist [3];
    logic [2:0]   cols_in_row;

    t_pixel expected_pixels [$];
    int     mismatch_count = 0;
    int     waiting = 0;

    assign o_error_count = mismatch_count;
    assign o_pending     = waiting;

    // Signed 16-bit coefficient from a packed register
    function automatic longint coef_at(input logic [47:0] word, input int slot);
        logic signed [lfd_pkg::COEF_W-1:0] c;
        c = word[slot*lfd_pkg::COEF_W +: lfd_pkg::COEF_W];
        return longint'(c);
    endfunction

    function automatic longint pair(input logic [W-1:0] a, input logic [W-1:0] b);
        return longint'(a) + longint'(b);
    endfunction

    // Filter the column three places back, then shift the new column in
    task automatic filter_column();
        longint    sum;
        longint    q;
        longint    maxv;
        int        bits;
        logic [W-1:0] mid;
        t_far_rows far_now;
        mid = col.center_sample;
        sum = coef_at({16'h0, coef_vert}, 0) * pair(far_hist[2].up3, far_hist[2].dn3)
            + coef_at({16'h0, coef_vert}, 1) * pair(far_hist[2].up2, far_hist[2].dn2)
            + coef_at(coef_ring, 0) * pair(up_hist[3], dn_hist[1])
            + coef_at(coef_ring, 1) * pair(up_hist[2], dn_hist[2])
            + coef_at(coef_ring, 2) * pair(up_hist[1], dn_hist[3])
            + coef_at(coef_row, 0) * pair(mid_hist[5], mid)
            + coef_at(coef_row, 1) * pair(mid_hist[4], mid_hist[0])
            + coef_at(coef_row, 2) * pair(mid_hist[3], mid_hist[1])
            + longint'(coef_mid) * longint'(mid_hist[2]);
        // floor shift, then clamp to the configured depth
        q    = (sum + lfd_pkg::ROUND_OFFSET) >>> lfd_pkg::ROUND_SHIFT;
        bits = (clamp_depth < SAMPLE_BITS) ? int'(clamp_depth) : SAMPLE_BITS;
        maxv = (longint'(1) << bits) - 1;
        if (q < 0) q = 0;
        if (q > maxv) q = maxv;

        for (int k = 5; k > 0; k--) mid_hist[k] = mid_hist[k-1];
        mid_hist[0] = mid;
        for (int k = 3; k > 0; k--) begin
            up_hist[k] = up_hist[k-1];
            dn_hist[k] = dn_hist[k-1];
        end
        up_hist[0] = col.above_one;
        dn_hist[0] = col.below_one;
        far_now = '{col.above_three, col.above_two, col.below_two, col.below_three};
        far_hist[2] = far_hist[1];
        far_hist[1] = far_hist[0];
        far_hist[0] = far_now;

        if (col.row_begin)
            cols_in_row = 3'd1;
        else if (cols_in_row < lfd_pkg::FILL_FULL)
            cols_in_row = cols_in_row + 3'd1;

        if (cols_in_row == lfd_pkg::FILL_FULL)
            expected_pixels.push_back('{q[W-1:0], col.row_end});
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (!i_rst_n) begin
            coef_vert   = '0;
            coef_ring   = '0;
            coef_row    = '0;
            coef_mid    = 16'sd64;
            clamp_depth = 4'd10;
            for (int k = 0; k < 6; k++) mid_hist[k] = '0;
            for (int k = 0; k < 4; k++) begin
                up_hist[k] = '0;
                dn_hist[k] = '0;
            end
            for (int k = 0; k < 3; k++) far_hist[k] = '0;
            cols_in_row = '0;
            expected_pixels.delete();
        end else begin
            // result side first: it is always older than a same-edge request
            if (pix.valid && pix.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel %0d last_in_row %0b", $time,
                             pix.filtered_sample, pix.last_in_row);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (pix.filtered_sample !== want.value) begin
                        $display("%0t: filtered_sample expected %0d, got %0d", $time,
                                 want.value, pix.filtered_sample);
                        mismatch_count++;
                    end
                    if (pix.last_in_row !== want.last) begin
                        $display("%0t: last_in_row expected %0b, got %0b", $time,
                                 want.last, pix.last_in_row);
                        mismatch_count++;
                    end
                end
            end

            // register writes; unused indexes fall through
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lfd_pkg::CFG_COEF_VERT:   coef_vert = i_cfg_data[31:0];
                    lfd_pkg::CFG_COEF_RING:   coef_ring = i_cfg_data[47:0];
                    lfd_pkg::CFG_COEF_ROW:    coef_row  = i_cfg_data[47:0];
                    lfd_pkg::CFG_COEF_CENTER: coef_mid  = i_cfg_data[lfd_pkg::COEF_W-1:0];
                    lfd_pkg::CFG_SAMPLE_BITS:
                        clamp_depth = i_cfg_data[lfd_pkg::BITS_CFG_W-1:0];
                    default: ;
                endcase
            end

            if (col.valid && col.ready)
                filter_column();
        end
        waiting = expected_pixels.size();
    end

endmodule

// ===== dv/loop_filter_diamond_column_stream_tb.sv =====
// Stimulus, flow control and verdict for the diamond column loop filter.
module loop_filter_diamond_column_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS  = 10;
    localparam int W            = SAMPLE_BITS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 88;
    localparam logic [lfd_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        lfd_pkg::CFG_SAMPLE_BITS + 1'b1;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [W-1:0] up3;
        logic [W-1:0] up2;
        logic [W-1:0] up1;
        logic [W-1:0] mid;
        logic [W-1:0] dn1;
        logic [W-1:0] dn2;
        logic [W-1:0] dn3;
        logic         row_begin;
        logic         row_end;
    } t_column;

    typedef struct packed {
        logic [31:0] vert;
        logic [47:0] ring;
        logic [47:0] row;
        logic [15:0] mid;
    } t_coef_set;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [lfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int error_count;
    int pending_count;
    int cycle_count = 0;

    lfd_col_if #(.W(W)) col_ch ();
    lfd_pix_if #(.W(W)) pix_ch ();

    always #5 i_clk = ~i_clk;

    loop_filter_diamond_column_stream #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_col       (col_ch),
        .o_pix       (pix_ch)
    );

    lfd_pixel_check #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .col           (col_ch),
        .pix           (pix_ch),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Pixel receiver: random stalls, or one long hold-off on request
    initial begin
        pix_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                pix_ch.ready <= (recv_stall_pct == 0) ||
                                ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_column uniform_column(input logic [W-1:0] v);
        return '{v, v, v, v, v, v, v, 1'b0, 1'b0};
    endfunction

    function automatic t_column rand_column();
        t_column c;
        int      style;
        style = $urandom_range(0, 9);
        if (style == 0)
            c = uniform_column('1);
        else if (style == 1)
            c = uniform_column('0);
        else
            c = '{W'($urandom), W'($urandom), W'($urandom), W'($urandom),
                  W'($urandom), W'($urandom), W'($urandom), 1'b0, 1'b0};
        return c;
    endfunction

    function automatic t_column mark(input t_column c, input bit b, input bit e);
        c.row_begin = b;
        c.row_end   = e;
        return c;
    endfunction

    // Small taps with unity DC gain: 2 * (sum of paired taps) + center = 64
    function automatic t_coef_set unity_gain_coefs();
        t_coef_set s;
        logic [15:0] c [8];
        int total;
        total = 0;
        for (int i = 0; i < 8; i++) begin
            c[i] = 16'(int'($urandom_range(0, 40)) - 20);
            total += int'($signed(c[i]));
        end
        s.vert = {c[1], c[0]};
        s.ring = {c[4], c[3], c[2]};
        s.row  = {c[7], c[6], c[5]};
        s.mid  = 16'(64 - 2 * total);
        return s;
    endfunction

    function automatic t_coef_set wild_coefs();
        return '{32'($urandom), {16'($urandom), 32'($urandom)},
                 {16'($urandom), 32'($urandom)}, 16'($urandom)};
    endfunction

    // Register writes, one per cycle, junk in the unused upper data bits
    task automatic program_filter(input t_coef_set s, input logic [3:0] depth,
                                  input bit poke_unused);
        logic [lfd_pkg::CFG_IDX_W-1:0]  idx [$];
        logic [lfd_pkg::CFG_DATA_W-1:0] val [$];
        logic [63:0]                    junk;
        junk = {$urandom, $urandom};
        idx.push_back(lfd_pkg::CFG_COEF_VERT);   val.push_back({junk[15:0], s.vert});
        idx.push_back(lfd_pkg::CFG_COEF_RING);   val.push_back(s.ring);
        idx.push_back(lfd_pkg::CFG_COEF_ROW);    val.push_back(s.row);
        idx.push_back(lfd_pkg::CFG_COEF_CENTER); val.push_back({junk[31:0], s.mid});
        idx.push_back(lfd_pkg::CFG_SAMPLE_BITS); val.push_back({junk[43:0], depth});
        if (poke_unused) begin
            for (int u = CFG_FIRST_UNUSED; u < 2**lfd_pkg::CFG_IDX_W; u++) begin
                idx.push_back(lfd_pkg::CFG_IDX_W'(u));
                val.push_back(lfd_pkg::CFG_DATA_W'({$urandom, $urandom}));
            end
        end
        foreach (idx[k]) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic void set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            IDLE_BOTH: begin send_idle_pct = 17; recv_stall_pct = 17; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    // One column request; starts and returns at a falling edge, valid left high
    task automatic send_column(input t_column c);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            col_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        col_ch.valid         <= 1'b1;
        col_ch.above_three   <= c.up3;
        col_ch.above_two     <= c.up2;
        col_ch.above_one     <= c.up1;
        col_ch.center_sample <= c.mid;
        col_ch.below_one     <= c.dn1;
        col_ch.below_two     <= c.dn2;
        col_ch.below_three   <= c.dn3;
        col_ch.row_begin     <= c.row_begin;
        col_ch.row_end       <= c.row_end;
        do @(posedge i_clk); while (!col_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_row(input int len, input bit with_begin, input bit with_end,
                            input bit noisy);
        t_column c;
        for (int i = 0; i < len; i++) begin
            c = mark(rand_column(), with_begin && i == 0, with_end && i == len - 1);
            if (noisy) begin
                c.row_begin = c.row_begin | ($urandom_range(0, 3) == 0);
                c.row_end   = c.row_end | ($urandom_range(0, 3) == 0);
            end
            send_column(c);
        end
    endtask

    // Mostly well-formed rows, some short, headless or with stray flags
    task automatic run_random(input int item_goal);
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < item_goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                   : $urandom_range(7, 20);
                send_row(len, 1'b1, 1'b1, 1'b0);
            end else if (kind < 88) begin
                len = $urandom_range(1, 6);
                send_row(len, 1'b1, 1'b1, 1'b0);
            end else if (kind < 94) begin
                len = $urandom_range(1, 12);
                send_row(len, 1'b0, 1'b1, 1'b0);
            end else begin
                len = $urandom_range(1, 10);
                send_row(len, 1'b1, 1'b1, 1'b1);
            end
            sent += len;
        end
    endtask

    // Let every expected pixel arrive and the pipeline empty
    task automatic finish_phase();
        col_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [W-1:0] pattern [8];
        t_coef_set    coefs;
        logic [3:0]   depth;
        col_ch.valid         = 1'b0;
        col_ch.above_three   = '0;
        col_ch.above_two     = '0;
        col_ch.above_one     = '0;
        col_ch.center_sample = '0;
        col_ch.below_one     = '0;
        col_ch.below_two     = '0;
        col_ch.below_three   = '0;
        col_ch.row_begin     = 1'b0;
        col_ch.row_end       = 1'b0;
        pattern = '{10'h3FF, 10'h000, 10'h2AA, 10'h155, 10'h3FF, 10'h000, 10'h155, 10'h2AA};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(IDLE_NONE);

        // Default taps pass the center through: full row, short row, headless tail
        for (int i = 0; i < 8; i++)
            send_column(mark(uniform_column(pattern[i]), i == 0, i == 7));
        for (int i = 0; i < 5; i++)
            send_column(mark(rand_column(), i == 0, i == 4));
        for (int i = 0; i < 2; i++)
            send_column(mark(rand_column(), 1'b0, i == 1));
        finish_phase();

        // Largest taps, 8-bit clamp, writes to unused indexes
        program_filter('{32'h7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 16'h7FFF},
                       4'd8, 1'b1);
        for (int i = 0; i < 7; i++)
            send_column(mark(uniform_column('1), i == 0, i == 6));
        finish_phase();

        // Most negative taps, zero clamp depth
        program_filter('{32'h8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 16'h8000},
                       4'd0, 1'b0);
        for (int i = 0; i < 7; i++)
            send_column(mark(uniform_column('1), i == 0, i == 6));
        finish_phase();

        // Random phases across taps, depths and idling patterns
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: depth = 4'd15;
                1: depth = 4'd8;
                2: depth = 4'd9;
                5: depth = 4'($urandom_range(0, 15));
                6: depth = 4'd8;
                default: depth = 4'd10;
            endcase
            coefs = (p == 3 || p == 6) ? wild_coefs() : unity_gain_coefs();
            program_filter(coefs, depth, p == 7);
            set_idling(t_idle_mode'(p % 4));
            if (p == 4) begin
                // output held off while columns keep coming
                hold_req = 1'b1;
                send_row(48, 1'b1, 1'b1, 1'b0);
            end
            run_random(PHASE_ITEMS);
            finish_phase();
        end

        if (error_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
